[rtl/size_class_free_list_allocator_core_macros.svh]
// Assertion macros for the size-class free-list allocator checker.
// Needs nothing else; included by the checker file only.
`ifndef SIZE_CLASS_FREE_LIST_ALLOCATOR_CORE_MACROS_SVH
`define SIZE_CLASS_FREE_LIST_ALLOCATOR_CORE_MACROS_SVH

// same-cycle implication, disabled while in reset
`define SFLA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("sfla: same-cycle check failed");

// next-cycle implication, disabled while in reset
`define SFLA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("sfla: next-cycle check failed");

`endif

[rtl/sfla_pkg.sv]
// Shared types and constants of the size-class free-list allocator.
// No dependencies; used by every other file of the block but the assertion macro header.
`timescale 1ns / 1ps
package sfla_pkg;

	localparam int OP_W        = 2;
	localparam int SIZE_W      = 12;
	localparam int HANDLE_W    = 10;
	localparam int STATUS_W    = 2;
	localparam int CLASS_OUT_W = 4;
	localparam int CNT_W       = 11;
	localparam int POOL_BLOCKS = 1 << HANDLE_W;

	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	typedef enum logic [OP_W-1:0] {
		OP_ALLOC = 2'd0,
		OP_FREE  = 2'd1,
		OP_ADD   = 2'd2,
		OP_QUERY = 2'd3
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_EMPTY     = 2'd1,
		ST_BAD_SIZE  = 2'd2,
		ST_UNDERFLOW = 2'd3
	} status_t;

	// one link entry: next handle plus a flag saying the next handle exists
	typedef struct packed {
		logic                valid;
		logic [HANDLE_W-1:0] next;
	} link_entry_t;

endpackage

[rtl/sfla_ifs.sv]
// Valid/ready channel interfaces for the allocator request and response items.
// Depends on sfla_pkg for field widths.
`timescale 1ns / 1ps
interface sfla_req_if;
	logic                          valid;
	logic                          ready;
	logic [sfla_pkg::OP_W-1:0]     operation;
	logic [sfla_pkg::SIZE_W-1:0]   size_bytes;
	logic [sfla_pkg::HANDLE_W-1:0] block_in;

	modport source (output valid, output operation, output size_bytes, output block_in,
		input ready);
	modport sink (input valid, input operation, input size_bytes, input block_in,
		output ready);
endinterface

interface sfla_rsp_if;
	logic                             valid;
	logic                             ready;
	logic [sfla_pkg::HANDLE_W-1:0]    block_out;
	logic [sfla_pkg::STATUS_W-1:0]    status;
	logic [sfla_pkg::CLASS_OUT_W-1:0] size_class;
	logic [sfla_pkg::CNT_W-1:0]       blocks_in_use;
	logic [sfla_pkg::CNT_W-1:0]       peak_in_use;
	logic [sfla_pkg::CNT_W-1:0]       blocks_added;

	modport source (output valid, output block_out, output status, output size_class,
		output blocks_in_use, output peak_in_use, output blocks_added, input ready);
	modport sink (input valid, input block_out, input status, input size_class,
		input blocks_in_use, input peak_in_use, input blocks_added, output ready);
endinterface

[rtl/size_class_free_list_allocator_core.sv]
// Size-class free-list allocator: one LIFO list of block handles per size class, with
// per-class in-use, peak and added counters. An accepted item lands in an input register;
// it is processed against the class registers once the output register is free and no
// pop is pending, and its result is loaded into the output register. Free, add, query and
// bad-size items go at one item per cycle while results are taken. A popping allocate
// holds the next item in the input register until the new head, read from the registered
// link read port in the cycle after the pop, is written. The link memory is not cleared.
`timescale 1ns / 1ps
module size_class_free_list_allocator_core #(
	parameter int CLASS_SPACING  = 8,
	parameter int NUM_CLASSES    = 16,
	parameter int MAX_SIZE_BYTES = 128
) (
	input logic        clk,
	input logic        arst_n,
	sfla_req_if.sink   req,
	sfla_rsp_if.source rsp
);
	localparam int CLS_W = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
	localparam int HW    = sfla_pkg::HANDLE_W;
	localparam int CW    = sfla_pkg::CNT_W;

	// input stage
	logic                  dec_bad;
	logic [CLS_W-1:0]      dec_cls;
	logic                  v_s1;
	sfla_pkg::op_t         op_s1;
	logic                  bad_s1;
	logic [CLS_W-1:0]      cls_s1;
	logic [HW-1:0]         blk_s1;
	logic                  accept;
	logic                  s1_fire;

	// class state
	logic [HW-1:0]         head_q  [NUM_CLASSES];
	logic                  ne_q    [NUM_CLASSES];
	logic [CW-1:0]         use_q   [NUM_CLASSES];
	logic [CW-1:0]         peak_q  [NUM_CLASSES];
	logic [CW-1:0]         add_q   [NUM_CLASSES];
	logic                  pop_pend_q;
	logic [CLS_W-1:0]      pop_cls_q;

	// processing
	logic [HW-1:0]         cur_head;
	logic                  cur_ne;
	logic [CW-1:0]         cur_use;
	logic [CW-1:0]         cur_peak;
	logic [CW-1:0]         cur_add;
	logic [CW-1:0]         new_use;
	logic [CW-1:0]         new_peak;
	logic [CW-1:0]         new_add;
	sfla_pkg::status_t     status_d;
	logic [HW-1:0]         blk_out_d;
	logic                  do_push;
	logic                  do_pop;
	sfla_pkg::link_entry_t link_wdata;
	sfla_pkg::link_entry_t link_rdata;

	// result register
	logic                  rsp_valid_q;
	logic [HW-1:0]         blk_out_q;
	sfla_pkg::status_t     status_q;
	logic [sfla_pkg::CLASS_OUT_W-1:0] class_q;
	logic [CW-1:0]         use_out_q;
	logic [CW-1:0]         peak_out_q;
	logic [CW-1:0]         add_out_q;

	sfla_size_decode #(
		.CLASS_SPACING  (CLASS_SPACING),
		.NUM_CLASSES    (NUM_CLASSES),
		.MAX_SIZE_BYTES (MAX_SIZE_BYTES)
	) u_decode (
		.size_bytes (req.size_bytes),
		.bad        (dec_bad),
		.cls        (dec_cls)
	);

	assign s1_fire   = v_s1 && !pop_pend_q && (!rsp_valid_q || rsp.ready);
	assign req.ready = !v_s1 || s1_fire;
	assign accept    = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (s1_fire) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1  <= sfla_pkg::op_t'(req.operation);
			bad_s1 <= dec_bad;
			cls_s1 <= dec_cls;
			blk_s1 <= req.block_in;
		end
	end

	always_comb begin
		cur_head  = head_q[cls_s1];
		cur_ne    = ne_q[cls_s1];
		cur_use   = use_q[cls_s1];
		cur_peak  = peak_q[cls_s1];
		cur_add   = add_q[cls_s1];
		new_use   = cur_use;
		new_peak  = cur_peak;
		new_add   = cur_add;
		status_d  = sfla_pkg::ST_OK;
		blk_out_d = '0;
		do_push   = 1'b0;
		do_pop    = 1'b0;
		if (bad_s1) begin
			status_d = sfla_pkg::ST_BAD_SIZE;
		end else begin
			case (op_s1)
				sfla_pkg::OP_ALLOC: begin
					if (!cur_ne) begin
						status_d = sfla_pkg::ST_EMPTY;
					end else begin
						do_pop    = 1'b1;
						blk_out_d = cur_head;
						if (cur_use != sfla_pkg::CNT_MAX) begin
							new_use = cur_use + CW'(1);
						end
						if (new_use > cur_peak) begin
							new_peak = new_use;
						end
					end
				end
				sfla_pkg::OP_FREE: begin
					do_push = 1'b1;
					if (cur_use == '0) begin
						status_d = sfla_pkg::ST_UNDERFLOW;
					end else begin
						new_use = cur_use - CW'(1);
					end
				end
				sfla_pkg::OP_ADD: begin
					do_push = 1'b1;
					if (cur_add != sfla_pkg::CNT_MAX) begin
						new_add = cur_add + CW'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	// push links the new handle in front of the old head
	assign link_wdata.valid = cur_ne;
	assign link_wdata.next  = cur_head;

	sfla_link_ram u_link (
		.clk   (clk),
		.we    (s1_fire && do_push),
		.waddr (blk_s1),
		.wdata (link_wdata),
		.raddr (cur_head),
		.rdata (link_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CLASSES; i++) begin
				head_q[i] <= '0;
				ne_q[i]   <= 1'b0;
				use_q[i]  <= '0;
				peak_q[i] <= '0;
				add_q[i]  <= '0;
			end
			pop_pend_q <= 1'b0;
			pop_cls_q  <= '0;
		end else begin
			if (s1_fire && !bad_s1) begin
				use_q[cls_s1]  <= new_use;
				peak_q[cls_s1] <= new_peak;
				add_q[cls_s1]  <= new_add;
				if (do_push) begin
					head_q[cls_s1] <= blk_s1;
					ne_q[cls_s1]   <= 1'b1;
				end
			end
			// pop finishes in the following cycle, once the link read data is back
			if (s1_fire && do_pop) begin
				pop_pend_q <= 1'b1;
				pop_cls_q  <= cls_s1;
			end else if (pop_pend_q) begin
				pop_pend_q         <= 1'b0;
				ne_q[pop_cls_q]    <= link_rdata.valid;
				head_q[pop_cls_q]  <= link_rdata.valid ? link_rdata.next : '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (s1_fire) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			blk_out_q <= blk_out_d;
			status_q  <= status_d;
			if (bad_s1) begin
				class_q    <= '0;
				use_out_q  <= '0;
				peak_out_q <= '0;
				add_out_q  <= '0;
			end else begin
				class_q    <= sfla_pkg::CLASS_OUT_W'(cls_s1);
				use_out_q  <= new_use;
				peak_out_q <= new_peak;
				add_out_q  <= new_add;
			end
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.block_out     = blk_out_q;
	assign rsp.status        = status_q;
	assign rsp.size_class    = class_q;
	assign rsp.blocks_in_use = use_out_q;
	assign rsp.peak_in_use   = peak_out_q;
	assign rsp.blocks_added  = add_out_q;

endmodule

[rtl/sfla_size_decode.sv]
// Maps a request size in bytes to its size class and flags sizes out of range.
// Depends on sfla_pkg for the size width.
`timescale 1ns / 1ps
module sfla_size_decode #(
	parameter int CLASS_SPACING  = 8,
	parameter int NUM_CLASSES    = 16,
	parameter int MAX_SIZE_BYTES = 128,
	localparam int CLS_W = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1
) (
	input  logic [sfla_pkg::SIZE_W-1:0] size_bytes,
	output logic                        bad,
	output logic [CLS_W-1:0]            cls
);
	// (size-1)/spacing as a multiply by a rounded-up reciprocal, exact for 12-bit operands
	localparam int SW    = sfla_pkg::SIZE_W;
	localparam int LOG_D = $clog2(CLASS_SPACING);
	localparam int SH    = SW + LOG_D;
	localparam int MUL   = ((1 << SH) + CLASS_SPACING - 1) / CLASS_SPACING;
	localparam int MW    = $clog2(MUL + 1);
	localparam int PW    = SW + MW;

	logic [SW-1:0] size_m1;
	logic [PW-1:0] prod;
	logic [SW-1:0] quot;

	assign size_m1 = size_bytes - SW'(1);
	assign prod    = PW'(size_m1) * PW'(MUL);
	assign quot    = SW'(prod >> SH);

	assign bad = (size_bytes == '0) ||
		({1'b0, size_bytes} > (SW+1)'(MAX_SIZE_BYTES)) ||
		(quot >= SW'(NUM_CLASSES));
	assign cls = quot[CLS_W-1:0];

endmodule

[rtl/sfla_link_ram.sv]
// Link memory: per handle, the next handle on its free list and a next-valid flag.
// One write port, one read port with registered read data. Depends on sfla_pkg.
`timescale 1ns / 1ps
module sfla_link_ram (
	input  logic                          clk,
	input  logic                          we,
	input  logic [sfla_pkg::HANDLE_W-1:0] waddr,
	input  sfla_pkg::link_entry_t         wdata,
	input  logic [sfla_pkg::HANDLE_W-1:0] raddr,
	output sfla_pkg::link_entry_t         rdata
);
	sfla_pkg::link_entry_t mem [sfla_pkg::POOL_BLOCKS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

[rtl/sfla_checker.sv]
// Port-level checks on the allocator response channel, bound to the top level.
// Depends on sfla_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "size_class_free_list_allocator_core_macros.svh"
module sfla_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                rsp_valid,
	input logic                                rsp_ready,
	input logic [sfla_pkg::HANDLE_W-1:0]       block_out,
	input logic [sfla_pkg::STATUS_W-1:0]       status,
	input logic [sfla_pkg::CLASS_OUT_W-1:0]    size_class,
	input logic [sfla_pkg::CNT_W-1:0]          blocks_in_use,
	input logic [sfla_pkg::CNT_W-1:0]          peak_in_use,
	input logic [sfla_pkg::CNT_W-1:0]          blocks_added
);
	// a stalled item holds
	`SFLA_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(block_out) && $stable(status) && $stable(blocks_in_use))

	// bad size reports nothing of any class
	`SFLA_ASSERT_NOW(a_bad_zero, clk, arst_n, rsp_valid && (status == sfla_pkg::ST_BAD_SIZE), (block_out == '0) && (size_class == '0) && (blocks_in_use == '0) && (peak_in_use == '0) && (blocks_added == '0))

	// peak never trails the in-use count
	`SFLA_ASSERT_NOW(a_peak_ge_use, clk, arst_n, rsp_valid, peak_in_use >= blocks_in_use)

	// only a successful pop hands out a handle
	`SFLA_ASSERT_NOW(a_blk_only_ok, clk, arst_n, rsp_valid && (status != sfla_pkg::ST_OK), block_out == '0)

endmodule

bind size_class_free_list_allocator_core sfla_checker u_sfla_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.block_out     (rsp.block_out),
	.status        (rsp.status),
	.size_class    (rsp.size_class),
	.blocks_in_use (rsp.blocks_in_use),
	.peak_in_use   (rsp.peak_in_use),
	.blocks_added  (rsp.blocks_added)
);

[tb/tb_size_class_free_list_allocator_core.sv]
// Self-checking bench for size_class_free_list_allocator_core: directed rows, then random
// traffic, each result checked against a typed expectation or an in-bench predictor.
// Depends on sfla_pkg, sfla_ifs and the core itself.
`timescale 1ns / 1ps
module tb_size_class_free_list_allocator_core;
	import sfla_pkg::*;

	localparam int SPACING     = 8;
	localparam int NCLS        = 16;
	localparam int MAX_BYTES   = 128;
	localparam int HOLD_CYCLES = 300;
	localparam int RAND_ITEMS  = 1075;

	typedef struct packed {
		logic [HANDLE_W-1:0] block;
		status_t             status;
		logic [3:0]          cls;
		logic [CNT_W-1:0]    in_use;
		logic [CNT_W-1:0]    peak;
		logic [CNT_W-1:0]    added;
	} alloc_result_t;

	typedef struct {
		op_t                 op;
		logic [SIZE_W-1:0]   size;
		logic [HANDLE_W-1:0] blk;
		bit                  typed;
		alloc_result_t       res;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n;

	sfla_req_if req_ch ();
	sfla_rsp_if rsp_ch ();

	size_class_free_list_allocator_core #(
		.CLASS_SPACING (SPACING),
		.NUM_CLASSES   (NCLS),
		.MAX_SIZE_BYTES(MAX_BYTES)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// predictor copy of the free lists and counters
	logic [HANDLE_W-1:0] cls_head [NCLS];
	logic                cls_live [NCLS];
	logic [HANDLE_W-1:0] next_of  [POOL_BLOCKS];
	logic                next_ok  [POOL_BLOCKS];
	logic [CNT_W-1:0]    in_use   [NCLS];
	logic [CNT_W-1:0]    peak     [NCLS];
	logic [CNT_W-1:0]    added    [NCLS];

	alloc_result_t awaited_results[$];
	alloc_result_t last_result;

	int  burst_left;
	bit  hold_req;
	int  mismatches;
	int  checked;
	int  op_count [4];
	int  empty_seen, bad_seen, underflow_seen;

	function automatic alloc_result_t mk_res(int blk, status_t st, int cls, int iu, int pk,
		int ad);
		alloc_result_t r;
		r.block  = blk[HANDLE_W-1:0];
		r.status = st;
		r.cls    = cls[3:0];
		r.in_use = iu[CNT_W-1:0];
		r.peak   = pk[CNT_W-1:0];
		r.added  = ad[CNT_W-1:0];
		return r;
	endfunction

	function automatic stim_row_t stim_row(op_t op, int size, int blk, bit typed,
		alloc_result_t res);
		stim_row_t s;
		s.op    = op;
		s.size  = size[SIZE_W-1:0];
		s.blk   = blk[HANDLE_W-1:0];
		s.typed = typed;
		s.res   = res;
		return s;
	endfunction

	function automatic logic [HANDLE_W-1:0] rnd_handle();
		return HANDLE_W'($urandom_range(0, POOL_BLOCKS - 1));
	endfunction

	// any size that maps to class c
	function automatic logic [SIZE_W-1:0] size_in_class(int c);
		return SIZE_W'(c * SPACING + $urandom_range(1, SPACING));
	endfunction

	function automatic void push_block(int c, logic [HANDLE_W-1:0] h);
		next_ok[h]  = cls_live[c];
		next_of[h]  = cls_head[c];
		cls_head[c] = h;
		cls_live[c] = 1'b1;
	endfunction

	// applies one request to the predicted lists and returns the result it yields
	function automatic alloc_result_t next_allocator_result(op_t op, logic [SIZE_W-1:0] size,
		logic [HANDLE_W-1:0] h);
		alloc_result_t r;
		int c;
		r = '0;
		r.status = ST_OK;
		if (size == 0 || size > MAX_BYTES || (int'(size) - 1) / SPACING >= NCLS) begin
			r.status = ST_BAD_SIZE;
			return r;
		end
		c = (int'(size) - 1) / SPACING;
		case (op)
			OP_ALLOC: begin
				if (!cls_live[c]) begin
					r.status = ST_EMPTY;
				end else begin
					r.block     = cls_head[c];
					cls_live[c] = next_ok[r.block];
					cls_head[c] = next_ok[r.block] ? next_of[r.block] : '0;
					if (in_use[c] != CNT_MAX)
						in_use[c]++;
					if (in_use[c] > peak[c])
						peak[c] = in_use[c];
				end
			end
			OP_FREE: begin
				if (in_use[c] == 0)
					r.status = ST_UNDERFLOW;
				else
					in_use[c]--;
				push_block(c, h);
			end
			OP_ADD: begin
				push_block(c, h);
				if (added[c] != CNT_MAX)
					added[c]++;
			end
			default: ;
		endcase
		r.cls    = c[3:0];
		r.in_use = in_use[c];
		r.peak   = peak[c];
		r.added  = added[c];
		return r;
	endfunction

	// offers one item in bursts with random gaps; predicts on acceptance
	task automatic offer_request(op_t op, logic [SIZE_W-1:0] size, logic [HANDLE_W-1:0] h,
		bit typed, alloc_result_t typed_res);
		int gap;
		alloc_result_t exp_res;
		@(negedge clk);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				req_ch.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		req_ch.valid      <= 1'b1;
		req_ch.operation  <= op;
		req_ch.size_bytes <= size;
		req_ch.block_in   <= h;
		do
			@(posedge clk);
		while (!req_ch.ready);
		last_result = next_allocator_result(op, size, h);
		exp_res = typed ? typed_res : last_result;
		awaited_results = {awaited_results, exp_res};
		op_count[op]++;
	endtask

	// receiver: stall patterns drawn anew every window, plus one long hold-off
	initial begin
		int window;
		int mode;
		rsp_ch.ready = 1'b0;
		window = 0;
		mode = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end
			if (window == 0) begin
				window = $urandom_range(20, 120);
				mode = $urandom_range(0, 3);
			end
			window--;
			case (mode)
				0: rsp_ch.ready <= 1'b1;
				1: rsp_ch.ready <= 1'($urandom_range(0, 1));
				2: rsp_ch.ready <= (window % 3 == 0);
				default: rsp_ch.ready <= ($urandom_range(0, 9) != 0);
			endcase
		end
	end

	always @(posedge clk) begin : result_check
		alloc_result_t got;
		alloc_result_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			got.block  = rsp_ch.block_out;
			got.status = status_t'(rsp_ch.status);
			got.cls    = rsp_ch.size_class;
			got.in_use = rsp_ch.blocks_in_use;
			got.peak   = rsp_ch.peak_in_use;
			got.added  = rsp_ch.blocks_added;
			checked++;
			case (got.status)
				ST_EMPTY:     empty_seen++;
				ST_BAD_SIZE:  bad_seen++;
				ST_UNDERFLOW: underflow_seen++;
				default: ;
			endcase
			if (awaited_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result with nothing outstanding: blk=%0d st=%0d cls=%0d",
						$realtime, got.block, got.status, got.cls);
			end else begin
				want = awaited_results.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"%0t: mismatch exp blk=%0d st=%0d cls=%0d use=%0d ",
							"peak=%0d add=%0d | got blk=%0d st=%0d cls=%0d use=%0d ",
							"peak=%0d add=%0d"}, $realtime,
							want.block, want.status, want.cls, want.in_use, want.peak,
							want.added, got.block, got.status, got.cls, got.in_use,
							got.peak, got.added);
				end
			end
		end
	end

	initial begin
		#10_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		stim_row_t     directed_rows [25];
		alloc_result_t none;
		alloc_result_t bad;
		int            hot [3];
		int            handed_out[$];
		int            random_items;
		int            r, c, n, k, idx, drain;
		bit            hold_done;
		logic [HANDLE_W-1:0] h;
		op_t           op;

		for (int i = 0; i < NCLS; i++) begin
			cls_head[i] = '0;
			cls_live[i] = 1'b0;
			in_use[i]   = '0;
			peak[i]     = '0;
			added[i]    = '0;
		end
		burst_left = 0;
		hold_req = 1'b0;
		mismatches = 0;
		checked = 0;
		op_count = '{default: 0};
		empty_seen = 0;
		bad_seen = 0;
		underflow_seen = 0;
		req_ch.valid = 1'b0;
		req_ch.operation = OP_QUERY;
		req_ch.size_bytes = '0;
		req_ch.block_in = '0;
		arst_n = 1'b0;

		none = '0;
		bad  = mk_res(0, ST_BAD_SIZE, 0, 0, 0, 0);
		directed_rows[0]  = stim_row(OP_ALLOC, 1, 0, 1, mk_res(0, ST_EMPTY, 0, 0, 0, 0));
		directed_rows[1]  = stim_row(OP_QUERY, 128, 0, 1, mk_res(0, ST_OK, 15, 0, 0, 0));
		directed_rows[2]  = stim_row(OP_ALLOC, 0, 0, 1, bad);
		directed_rows[3]  = stim_row(OP_ADD, 129, 1023, 1, bad);
		directed_rows[4]  = stim_row(OP_FREE, 4095, 1023, 1, bad);
		directed_rows[5]  = stim_row(OP_QUERY, 4095, 0, 1, bad);
		directed_rows[6]  = stim_row(OP_FREE, 8, 5, 1, mk_res(0, ST_UNDERFLOW, 0, 0, 0, 0));
		directed_rows[7]  = stim_row(OP_ADD, 128, 1023, 1, mk_res(0, ST_OK, 15, 0, 0, 1));
		directed_rows[8]  = stim_row(OP_ADD, 121, 0, 1, mk_res(0, ST_OK, 15, 0, 0, 2));
		directed_rows[9]  = stim_row(OP_ALLOC, 128, 0, 1, mk_res(0, ST_OK, 15, 1, 1, 2));
		directed_rows[10] = stim_row(OP_ALLOC, 125, 0, 1, mk_res(1023, ST_OK, 15, 2, 2, 2));
		directed_rows[11] = stim_row(OP_ALLOC, 128, 0, 1, mk_res(0, ST_EMPTY, 15, 2, 2, 2));
		directed_rows[12] = stim_row(OP_FREE, 128, 1023, 0, none);
		directed_rows[13] = stim_row(OP_FREE, 9, 512, 0, none);
		directed_rows[14] = stim_row(OP_ALLOC, 16, 0, 0, none);
		directed_rows[15] = stim_row(OP_ADD, 64, 682, 0, none);
		directed_rows[16] = stim_row(OP_ADD, 57, 341, 0, none);
		directed_rows[17] = stim_row(OP_ALLOC, 64, 0, 0, none);
		directed_rows[18] = stim_row(OP_ALLOC, 60, 0, 0, none);
		directed_rows[19] = stim_row(OP_ALLOC, 64, 0, 0, none);
		directed_rows[20] = stim_row(OP_FREE, 64, 341, 0, none);
		directed_rows[21] = stim_row(OP_FREE, 64, 682, 0, none);
		directed_rows[22] = stim_row(OP_FREE, 64, 7, 0, none);
		directed_rows[23] = stim_row(OP_ALLOC, 1, 0, 0, none);
		directed_rows[24] = stim_row(OP_QUERY, 64, 0, 0, none);

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i])
			offer_request(directed_rows[i].op, directed_rows[i].size, directed_rows[i].blk,
				directed_rows[i].typed, directed_rows[i].res);

		// random part: a few hot classes so the lists get deep
		for (int i = 0; i < 3; i++)
			hot[i] = $urandom_range(0, NCLS - 1);
		random_items = 0;
		hold_done = 0;
		while (random_items < RAND_ITEMS) begin
			if (random_items >= 400 && !hold_done) begin
				hold_req = 1'b1;
				hold_done = 1;
			end
			c = ($urandom_range(0, 9) < 7) ? hot[$urandom_range(0, 2)]
				: $urandom_range(0, NCLS - 1);
			r = $urandom_range(0, 99);
			if (r < 8) begin
				// grow a class by n blocks, then allocate from it n+1 times
				n = $urandom_range(2, 8);
				for (k = 0; k < n; k++)
					offer_request(OP_ADD, size_in_class(c), rnd_handle(), 0, none);
				for (k = 0; k <= n; k++) begin
					offer_request(OP_ALLOC, size_in_class(c), 0, 0, none);
					if (last_result.status == ST_OK)
						handed_out = {handed_out, c * POOL_BLOCKS + int'(last_result.block)};
				end
				random_items += 2 * n + 1;
			end else if (r < 38) begin
				offer_request(OP_ALLOC, size_in_class(c), rnd_handle(), 0, none);
				if (last_result.status == ST_OK)
					handed_out = {handed_out, c * POOL_BLOCKS + int'(last_result.block)};
				random_items++;
			end else if (r < 63) begin
				h = rnd_handle();
				if (handed_out.size() > 0 && $urandom_range(0, 9) < 8) begin
					idx = $urandom_range(0, handed_out.size() - 1);
					c = handed_out[idx] / POOL_BLOCKS;
					h = HANDLE_W'(handed_out[idx] % POOL_BLOCKS);
					handed_out.delete(idx);
				end
				offer_request(OP_FREE, size_in_class(c), h, 0, none);
				random_items++;
			end else if (r < 85) begin
				offer_request(OP_ADD, size_in_class(c), rnd_handle(), 0, none);
				random_items++;
			end else if (r < 93) begin
				offer_request(OP_QUERY, size_in_class(c), rnd_handle(), 0, none);
				random_items++;
			end else begin
				op = op_t'($urandom_range(0, 3));
				case ($urandom_range(0, 2))
					0: offer_request(op, 0, rnd_handle(), 0, none);
					1: offer_request(op, SIZE_W'($urandom_range(MAX_BYTES + 1, 4095)),
						rnd_handle(), 0, none);
					default: offer_request(op, 4095, rnd_handle(), 0, none);
				endcase
				random_items++;
			end
		end

		@(negedge clk);
		req_ch.valid <= 1'b0;
		for (drain = 0; drain < 5000 && awaited_results.size() > 0; drain++)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (awaited_results.size() > 0) begin
			$display("%0d results never arrived", awaited_results.size());
			mismatches += awaited_results.size();
		end

		$display("Requests: %0d allocate, %0d free, %0d add, %0d query; %0d results checked.",
			op_count[OP_ALLOC], op_count[OP_FREE], op_count[OP_ADD], op_count[OP_QUERY],
			checked);
		$display("Seen: %0d empty, %0d bad size, %0d underflow.",
			empty_seen, bad_seen, underflow_seen);
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
